/* hw/rtl/interpolating_resampler_mixer_core_defines.svh */
// Assertion macros shared by the resampler RTL.
// No dependencies; include after the clock and reset names are known.
`ifndef INTERPOLATING_RESAMPLER_MIXER_CORE_DEFINES_SVH
`define INTERPOLATING_RESAMPLER_MIXER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define IRM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define IRM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/irm_pkg.sv */
// Shared types and constants of the interpolating resampler mixer.
// No dependencies; compiled before every other RTL file.
`default_nettype none

package irm_pkg;

  // Field and register widths
  localparam int SAMPLE_W   = 16;
  localparam int RATE_W     = 19;
  localparam int GAIN_W     = 8;
  localparam int FRAC_W     = 16;
  localparam int PHASE_W    = 20;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Default cap on results per source sample
  localparam int MAX_UPSAMPLE_DEF = 16;

  // 1.0 in 4.16 phase
  localparam logic [PHASE_W-1:0] ONE_Q16 = PHASE_W'(65536);

  // Register reset values
  localparam logic [RATE_W-1:0] RATE_STEP_RST = RATE_W'(65536);
  localparam logic [GAIN_W-1:0] GAIN_RST      = GAIN_W'(255);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATE_STEP   = 8'd0,
    REG_GAIN_LEFT   = 8'd1,
    REG_GAIN_RIGHT  = 8'd2,
    REG_STEREO_MODE = 8'd3
  } reg_idx_t;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Control that travels with each output position down the pipeline
  typedef struct packed {
    logic valid;
    logic run_last;
    logic sound_done;
  } tag_t;

endpackage

`default_nettype wire

/* hw/rtl/interpolating_resampler_mixer_core.sv */
// Top level of the linear-interpolation resampler feeding a mix bus.
// Depends on irm_pkg, irm_lane, irm_merge and the shared assertion macros.
//
// channel  direction  handshake              payload
// in       sink       in_valid / in_stall    sample_left, sample_right, restart, last_sample
// out      source     out_valid / out_stall  out_left, out_right, run_last, sound_done
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item is taken in an idle cycle, then the sequencer issues one output position per
// cycle unless the output stalls, up to MAX_UPSAMPLE (default 16) per item; in_stall holds the input meanwhile.
// Restart and downsampled items finish in their acceptance cycle.
// Each result passes through the three lane registers and the merge output register after issue.
// A stalled output freezes the whole lane pipeline and stops the sequencer issuing positions.
// Synchronous reset clears state, phase and previous samples and presets the registers; cfg_ready is always high.
`default_nettype none
`include "interpolating_resampler_mixer_core_defines.svh"

module interpolating_resampler_mixer_core #(
  parameter int MAX_UPSAMPLE = irm_pkg::MAX_UPSAMPLE_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [irm_pkg::SAMPLE_W-1:0]   sample_left,
  input  wire logic signed [irm_pkg::SAMPLE_W-1:0]   sample_right,
  input  wire logic                                 restart,
  input  wire logic                                 last_sample,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed      [irm_pkg::SAMPLE_W-1:0]   out_left,
  output logic signed      [irm_pkg::SAMPLE_W-1:0]   out_right,
  output logic                                      run_last,
  output logic                                      sound_done,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic        [irm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [irm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import irm_pkg::*;

  localparam int CNT_W = (MAX_UPSAMPLE > 1) ? $clog2(MAX_UPSAMPLE) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_UPSAMPLE - 1);

  // Configuration registers
  logic [RATE_W-1:0] rate_step;
  logic [GAIN_W-1:0] gain_left;
  logic [GAIN_W-1:0] gain_right;
  logic              stereo_mode;

  // Sequencer state
  state_t state;
  state_t state_next;
  logic [PHASE_W-1:0] phase;
  logic [CNT_W-1:0]   count;
  logic signed [SAMPLE_W-1:0] prev_left;
  logic signed [SAMPLE_W-1:0] prev_right;
  logic signed [SAMPLE_W-1:0] cur_left;
  logic signed [SAMPLE_W-1:0] cur_right;
  logic done;

  // Tag pipeline beside the lanes
  tag_t tag1;
  tag_t tag2;
  tag_t tag3;

  logic accept;
  logic adv;
  logic issue;
  logic issue_last;
  logic cnt_last;
  logic sum_wraps;
  logic [PHASE_W-1:0] phase_sum;
  logic [PHASE_W-1:0] phase_dec;
  logic [PHASE_W-1:0] sum_dec;
  logic signed [SAMPLE_W-1:0] res_left;
  logic signed [SAMPLE_W-1:0] res_right;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign adv       = !(out_valid && out_stall);

  // Phase arithmetic for the current position
  assign phase_sum  = phase + {1'b0, rate_step};
  assign phase_dec  = phase - ONE_Q16;
  assign sum_dec    = phase_sum - ONE_Q16;
  assign sum_wraps  = (phase_sum >= ONE_Q16);
  assign cnt_last   = (count == CNT_LAST);
  assign issue      = (state == ST_RUN) && adv;
  assign issue_last = sum_wraps || cnt_last;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_step   <= RATE_STEP_RST;
      gain_left   <= GAIN_RST;
      gain_right  <= GAIN_RST;
      stereo_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RATE_STEP:   rate_step   <= cfg_data[RATE_W-1:0];
        REG_GAIN_LEFT:   gain_left   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_RIGHT:  gain_right  <= cfg_data[GAIN_W-1:0];
        REG_STEREO_MODE: stereo_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: run only when the new sample leaves a position to emit
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && !restart && (phase < ONE_Q16)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue && issue_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Phase, count and sample history
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= '0;
      count      <= '0;
      prev_left  <= '0;
      prev_right <= '0;
    end else if (accept) begin
      if (restart) begin
        prev_left  <= sample_left;
        prev_right <= sample_right;
        phase      <= '0;
      end else if (phase >= ONE_Q16) begin
        prev_left  <= sample_left;
        prev_right <= sample_right;
        phase      <= {1'b0, phase_dec[RATE_W-1:0]};
      end else begin
        count <= '0;
      end
    end else if (issue) begin
      if (issue_last) begin
        prev_left  <= cur_left;
        prev_right <= cur_right;
        phase      <= sum_wraps ? {1'b0, sum_dec[RATE_W-1:0]} : '0;
      end else begin
        phase <= phase_sum;
        count <= count + 1'b1;
      end
    end
  end

  // Capture the new sample pair and last flag of every accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_left  <= sample_left;
      cur_right <= sample_right;
      done      <= last_sample;
    end
  end

  // Advance the tags with the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      tag3 <= '0;
    end else if (adv) begin
      tag1 <= '{valid: issue, run_last: issue_last, sound_done: done};
      tag2 <= tag1;
      tag3 <= tag2;
    end
  end

  irm_lane u_lane_left (
    .clk  (clk),
    .en   (adv),
    .prev (prev_left),
    .cur  (cur_left),
    .frac (phase[FRAC_W-1:0]),
    .gain (gain_left),
    .res  (res_left)
  );

  irm_lane u_lane_right (
    .clk  (clk),
    .en   (adv),
    .prev (prev_right),
    .cur  (cur_right),
    .frac (phase[FRAC_W-1:0]),
    .gain (gain_right),
    .res  (res_right)
  );

  irm_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .tag_in     (tag3),
    .stereo     (stereo_mode),
    .left_res   (res_left),
    .right_res  (res_right),
    .out_valid  (out_valid),
    .out_left   (out_left),
    .out_right  (out_right),
    .run_last   (run_last),
    .sound_done (sound_done)
  );

  // Sequencer and pipeline checks
  `IRM_ASSERT(a_run_phase, clk, rst, (state == ST_RUN) |-> (phase < ONE_Q16), "phase reached 1.0 while running")
  `IRM_ASSERT(a_idle_phase, clk, rst, (state == ST_IDLE) |-> (phase[PHASE_W-1] == 1'b0), "idle phase overflow")
  `IRM_ASSERT_NEXT(a_count_step, clk, rst, issue && !issue_last, count == $past(count) + 1'b1, "count did not advance")
  `IRM_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && out_stall, $stable(tag3) && out_valid, "pipeline moved under stall")

endmodule

`default_nettype wire

/* hw/rtl/irm_lane.sv */
// One interpolation lane: (new - prev) * frac, add prev, multiply by gain.
// Depends on irm_pkg for widths.
`default_nettype none

module irm_lane (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic signed [irm_pkg::SAMPLE_W-1:0] prev,
  input  wire logic signed [irm_pkg::SAMPLE_W-1:0] cur,
  input  wire logic        [irm_pkg::FRAC_W-1:0]   frac,
  input  wire logic        [irm_pkg::GAIN_W-1:0]   gain,
  output logic signed      [irm_pkg::SAMPLE_W-1:0] res
);
  import irm_pkg::*;

  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int ACC_W  = SAMPLE_W + FRAC_W + 1;
  localparam int GPROD_W = ACC_W + GAIN_W + 1;

  logic signed [DIFF_W-1:0]  diff;
  logic signed [DIFF_W-1:0]  frac_s;
  logic signed [PROD_W-1:0]  s1_prod;
  logic signed [SAMPLE_W-1:0] s1_base;
  logic signed [ACC_W-1:0]   base_ext;
  logic signed [ACC_W-1:0]   s2_acc;
  logic signed [GAIN_W:0]    gain_s;
  logic signed [GPROD_W-1:0] s3_prod;

  // Operands of the multiplies and the add
  assign diff     = {cur[SAMPLE_W-1], cur} - {prev[SAMPLE_W-1], prev};
  assign frac_s   = {1'b0, frac};
  assign base_ext = {s1_base[SAMPLE_W-1], s1_base, {FRAC_W{1'b0}}};
  assign gain_s   = {1'b0, gain};

  // Three registered steps; hold all of them while the output is stalled
  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod <= diff * frac_s;
      s1_base <= prev;
      s2_acc  <= base_ext + s1_prod[ACC_W-1:0];
      s3_prod <= s2_acc * gain_s;
    end
  end

  // Floor shift by 24 keeps bits 39 down to 24
  assign res = s3_prod[FRAC_W+GAIN_W+SAMPLE_W-1:FRAC_W+GAIN_W];

endmodule

`default_nettype wire

/* hw/rtl/irm_merge.sv */
// Output stage: combines the two lanes into one result and registers it.
// Depends on irm_pkg for tag_t and widths.
`default_nettype none

module irm_merge (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               en,
  input  wire irm_pkg::tag_t                      tag_in,
  input  wire logic                               stereo,
  input  wire logic signed [irm_pkg::SAMPLE_W-1:0] left_res,
  input  wire logic signed [irm_pkg::SAMPLE_W-1:0] right_res,
  output logic                                    out_valid,
  output logic signed      [irm_pkg::SAMPLE_W-1:0] out_left,
  output logic signed      [irm_pkg::SAMPLE_W-1:0] out_right,
  output logic                                    run_last,
  output logic                                    sound_done
);
  import irm_pkg::*;

  // Valid flag of the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= tag_in.valid;
    end
  end

  // Mono duplicates the left lane onto the right output
  always_ff @(posedge clk) begin
    if (en) begin
      out_left   <= left_res;
      out_right  <= stereo ? right_res : left_res;
      run_last   <= tag_in.run_last;
      sound_done <= tag_in.sound_done;
    end
  end

endmodule

`default_nettype wire
